>>> hw/rtl/lpfr_pkg.sv
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared types and constants of the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

    // Result status codes.
    localparam logic [2:0] ST_ACCEPTED   = 3'd0;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE   = 3'd2;
    localparam logic [2:0] ST_BAD_XOR    = 3'd3;
    localparam logic [2:0] ST_OVERSIZE   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_SYNC_BYTE      = 2'd0;
    localparam logic [1:0] REG_MAX_FRAME      = 2'd1;
    localparam logic [1:0] REG_EXPECTED_FRAME = 2'd2;
    localparam logic [1:0] REG_EXPECTED_TYPE  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_SYNC_BYTE      = 8'hBB;
    localparam logic [8:0] RST_MAX_FRAME      = 9'd100;
    localparam logic [8:0] RST_EXPECTED_FRAME = 9'd65;
    localparam logic [7:0] RST_EXPECTED_TYPE  = 8'h04;

    // Frame layout.
    localparam logic [8:0] HEADER_BYTES = 9'd3;
    localparam logic [8:0] TYPE_POS     = 9'd3;
    localparam logic [8:0] TEMP_HI_POS  = 9'd17;
    localparam logic [8:0] TEMP_LO_POS  = 9'd18;

    typedef struct packed {
        logic [7:0] sync_byte;
        logic [8:0] max_frame_bytes;
        logic [8:0] expected_frame_bytes;
        logic [7:0] expected_type;
    } lpfr_cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [8:0]  frame_bytes;
        logic [7:0]  frame_type;
        logic [15:0] temp_word;
    } lpfr_result_t;

endpackage

>>> hw/rtl/length_prefixed_frame_receiver.sv
// Each result is registered, in the output register or else in the skid entry.
// Throughput: one byte per cycle while s_ready is high; state updates once per beat.
// A two-entry output buffer (result register plus skid) keeps s_ready high while one
// result waits; s_ready drops only while both entries are full.
// Reset (synchronous, aresetn low) returns to hunting, empties the output buffer and
// restores the register defaults.
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Receives serial bytes, frames them by sync byte and length prefix, and
// reports one checked result per frame.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [8:0]  m_frame_bytes,
    output logic [7:0]  m_frame_type,
    output logic [15:0] m_temp_word
);
    import lpfr_pkg::*;

    lpfr_cfg_t    cfg_reg;
    lpfr_result_t new_result;
    lpfr_result_t out_reg;
    lpfr_result_t skid_reg;
    logic         new_valid;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         beat_in;
    logic         beat_out;
    logic         push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_byte            <= RST_SYNC_BYTE;
            cfg_reg.max_frame_bytes      <= RST_MAX_FRAME;
            cfg_reg.expected_frame_bytes <= RST_EXPECTED_FRAME;
            cfg_reg.expected_type        <= RST_EXPECTED_TYPE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SYNC_BYTE:      cfg_reg.sync_byte            <= cfg_wdata[7:0];
                REG_MAX_FRAME:      cfg_reg.max_frame_bytes      <= cfg_wdata;
                REG_EXPECTED_FRAME: cfg_reg.expected_frame_bytes <= cfg_wdata;
                REG_EXPECTED_TYPE:  cfg_reg.expected_type        <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign s_ready  = !skid_valid_reg;
    assign beat_in  = s_valid && s_ready;
    assign beat_out = out_valid_reg && m_ready;
    assign push     = beat_in && new_valid;

    lpfr_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .beat_en      (beat_in),
        .data_byte    (s_data_byte),
        .cfg          (cfg_reg),
        .result_valid (new_valid),
        .result       (new_result)
    );

    // A new result goes to the output register when it is free or draining,
    // otherwise it waits in the skid entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (beat_out) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_out) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (push) begin
                out_reg <= new_result;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_reg <= new_result;
            end else begin
                out_reg <= new_result;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_reg.status;
    assign m_frame_bytes = out_reg.frame_bytes;
    assign m_frame_type  = out_reg.frame_type;
    assign m_temp_word   = out_reg.temp_word;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid entry filled although the output register was free");

    a_temp_only_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_reg.status != ST_ACCEPTED)) |-> (out_reg.temp_word == 16'd0))
        else $error("temperature reported on a rejected frame");

endmodule

>>> hw/rtl/lpfr_parser.sv
// ----------------------------------------------------------------------------
// lpfr_parser
// Frame state tracking: hunting, header, length and payload sections, running
// XOR and field capture. Produces at most one result per byte.
// ----------------------------------------------------------------------------
module lpfr_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  beat_en,
    input  logic [7:0]            data_byte,
    input  lpfr_pkg::lpfr_cfg_t   cfg,
    output logic                  result_valid,
    output lpfr_pkg::lpfr_result_t result
);
    import lpfr_pkg::*;

    logic [8:0]  byte_position_reg, byte_position_next;
    logic [8:0]  bytes_remaining_reg, bytes_remaining_next;
    logic        awaiting_length_reg, awaiting_length_next;
    logic [7:0]  running_xor_reg, running_xor_next;
    logic [7:0]  captured_type_reg, captured_type_next;
    logic [15:0] captured_temp_reg, captured_temp_next;

    logic        hunting;
    logic        frame_start;
    logic        length_phase;
    logic        store_en;
    logic        oversize;
    logic        frame_done;
    logic [8:0]  pos_base;
    logic [7:0]  xor_base;
    logic [7:0]  type_base;
    logic [15:0] temp_base;
    logic [8:0]  pos_stored;
    logic [8:0]  length_total;
    logic [8:0]  remaining_dec;
    logic [9:0]  announced_end;

    always_comb begin
        hunting      = (bytes_remaining_reg == 9'd0) && !awaiting_length_reg;
        frame_start  = hunting && (data_byte == cfg.sync_byte);
        length_phase = awaiting_length_reg && (bytes_remaining_reg == 9'd0);

        // A sync byte restarts the frame before it is stored itself.
        pos_base  = frame_start ? 9'd0  : byte_position_reg;
        xor_base  = frame_start ? 8'd0  : running_xor_reg;
        type_base = frame_start ? 8'd0  : captured_type_reg;
        temp_base = frame_start ? 16'd0 : captured_temp_reg;

        // Bytes beyond the buffer still count down but are not stored.
        store_en = (frame_start || !hunting) && (pos_base < cfg.max_frame_bytes);

        running_xor_next   = store_en ? (xor_base ^ data_byte) : xor_base;
        captured_type_next = (store_en && (pos_base == TYPE_POS)) ? data_byte : type_base;
        captured_temp_next = temp_base;
        if (store_en && (pos_base == TEMP_HI_POS)) begin
            captured_temp_next[15:8] = data_byte;
        end
        if (store_en && (pos_base == TEMP_LO_POS)) begin
            captured_temp_next[7:0] = data_byte;
        end
        pos_stored = store_en ? (pos_base + 9'd1) : pos_base;

        length_total  = {1'b0, data_byte} + 9'd1;
        announced_end = {1'b0, length_total} + {1'b0, pos_stored};
        oversize      = length_phase && (announced_end > {1'b0, cfg.max_frame_bytes});

        remaining_dec = bytes_remaining_reg - 9'd1;
        frame_done    = !hunting && !length_phase && !awaiting_length_reg
                        && (remaining_dec == 9'd0);

        priority if (frame_start) begin
            bytes_remaining_next = HEADER_BYTES;
            awaiting_length_next = 1'b1;
        end else if (length_phase) begin
            bytes_remaining_next = oversize ? 9'd0 : length_total;
            awaiting_length_next = 1'b0;
        end else if (!hunting) begin
            bytes_remaining_next = remaining_dec;
            awaiting_length_next = awaiting_length_reg;
        end else begin
            bytes_remaining_next = bytes_remaining_reg;
            awaiting_length_next = awaiting_length_reg;
        end
        byte_position_next = oversize ? 9'd0 : pos_stored;

        result_valid       = oversize || frame_done;
        result.frame_bytes = pos_stored;
        result.frame_type  = captured_type_next;
        result.temp_word   = 16'd0;
        priority if (oversize) begin
            result.status = ST_OVERSIZE;
        end else if (pos_stored != cfg.expected_frame_bytes) begin
            result.status = ST_BAD_LENGTH;
        end else if (captured_type_next != cfg.expected_type) begin
            result.status = ST_BAD_TYPE;
        end else if (running_xor_next != 8'd0) begin
            result.status = ST_BAD_XOR;
        end else begin
            result.status    = ST_ACCEPTED;
            result.temp_word = captured_temp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg   <= 9'd0;
            bytes_remaining_reg <= 9'd0;
            awaiting_length_reg <= 1'b0;
            running_xor_reg     <= 8'd0;
            captured_type_reg   <= 8'd0;
            captured_temp_reg   <= 16'd0;
        end else if (beat_en) begin
            byte_position_reg   <= byte_position_next;
            bytes_remaining_reg <= bytes_remaining_next;
            awaiting_length_reg <= awaiting_length_next;
            running_xor_reg     <= running_xor_next;
            captured_type_reg   <= captured_type_next;
            captured_temp_reg   <= captured_temp_next;
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefixed frame receiver. A scoreboard
// class follows the hunting and framing state byte by byte and queues the
// result that each accepted beat should produce. Results from the block are
// checked in order. Stimulus is a short directed run followed by random
// frames over several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import lpfr_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 125;
    localparam int PHASE_COUNT  = 12;
    localparam int DRAIN_CYCLES = 4;

    typedef enum int {
        FR_GOOD,
        FR_BAD_LENGTH,
        FR_BAD_TYPE,
        FR_BAD_XOR,
        FR_OVERSIZE,
        FR_TRUNCATED,
        FR_NOISE
    } frame_kind_t;

    class frame_scoreboard;
        logic [7:0]   sync_value;
        logic [8:0]   max_frame;
        logic [8:0]   expected_frame;
        logic [7:0]   expected_type;
        logic [8:0]   pos;
        logic [8:0]   remaining;
        logic         in_header;
        logic [7:0]   xor_acc;
        logic [7:0]   type_cap;
        logic [15:0]  temp_cap;
        lpfr_result_t expected_results[$];
        int           mismatch_count;

        function new();
            sync_value     = RST_SYNC_BYTE;
            max_frame      = RST_MAX_FRAME;
            expected_frame = RST_EXPECTED_FRAME;
            expected_type  = RST_EXPECTED_TYPE;
            pos            = '0;
            remaining      = '0;
            in_header      = 1'b0;
            xor_acc        = '0;
            type_cap       = '0;
            temp_cap       = '0;
            mismatch_count = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [8:0] val);
            unique case (idx)
                REG_SYNC_BYTE:      sync_value     = val[7:0];
                REG_MAX_FRAME:      max_frame      = val;
                REG_EXPECTED_FRAME: expected_frame = val;
                REG_EXPECTED_TYPE:  expected_type  = val[7:0];
                default: ;
            endcase
        endfunction

        function bit is_hunting();
            return remaining == 0 && !in_header;
        endfunction

        // Bytes past the end of the buffer still count down but are dropped.
        function void store_byte(logic [7:0] b);
            if (pos >= max_frame)
                return;
            xor_acc = xor_acc ^ b;
            if (pos == TYPE_POS)
                type_cap = b;
            else if (pos == TEMP_HI_POS)
                temp_cap[15:8] = b;
            else if (pos == TEMP_LO_POS)
                temp_cap[7:0] = b;
            pos = pos + 9'd1;
        endfunction

        function void post_result(logic [2:0] st, logic [15:0] temp);
            lpfr_result_t r;
            r.status      = st;
            r.frame_bytes = pos;
            r.frame_type  = type_cap;
            r.temp_word   = temp;
            expected_results.push_back(r);
        endfunction

        function void advance_frame(logic [7:0] b);
            logic [9:0] span;
            if (is_hunting()) begin
                if (b != sync_value)
                    return;
                pos       = '0;
                xor_acc   = '0;
                type_cap  = '0;
                temp_cap  = '0;
                remaining = HEADER_BYTES;
                in_header = 1'b1;
                store_byte(b);
                return;
            end
            if (remaining == 0) begin
                // Length byte: the body is one byte longer than announced.
                store_byte(b);
                remaining = {1'b0, b} + 9'd1;
                in_header = 1'b0;
                span = {1'b0, remaining} + {1'b0, pos};
                if (span > {1'b0, max_frame}) begin
                    post_result(ST_OVERSIZE, 16'h0000);
                    pos       = '0;
                    remaining = '0;
                end
                return;
            end
            store_byte(b);
            remaining = remaining - 9'd1;
            if (remaining != 0 || in_header)
                return;
            if (pos != expected_frame)
                post_result(ST_BAD_LENGTH, 16'h0000);
            else if (type_cap != expected_type)
                post_result(ST_BAD_TYPE, 16'h0000);
            else if (xor_acc != 8'h00)
                post_result(ST_BAD_XOR, 16'h0000);
            else
                post_result(ST_ACCEPTED, temp_cap);
        endfunction

        function void check_result(lpfr_result_t got);
            lpfr_result_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected: status %0d, bytes %0d",
                         $time, got.status, got.frame_bytes);
                mismatch_count++;
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, got %0d",
                         $time, want.status, got.status);
                mismatch_count++;
            end
            if (got.frame_bytes !== want.frame_bytes) begin
                $display("%0t: frame_bytes mismatch: expected %0d, got %0d",
                         $time, want.frame_bytes, got.frame_bytes);
                mismatch_count++;
            end
            if (got.frame_type !== want.frame_type) begin
                $display("%0t: frame_type mismatch: expected %02h, got %02h",
                         $time, want.frame_type, got.frame_type);
                mismatch_count++;
            end
            if (got.temp_word !== want.temp_word) begin
                $display("%0t: temp_word mismatch: expected %04h, got %04h",
                         $time, want.temp_word, got.temp_word);
                mismatch_count++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_index   = REG_SYNC_BYTE;
    logic [8:0]  cfg_wdata   = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [2:0]  m_status;
    logic [8:0]  m_frame_bytes;
    logic [7:0]  m_frame_type;
    logic [15:0] m_temp_word;

    frame_scoreboard sb;
    int  send_idle_pct  = 31;
    int  recv_idle_pct  = 48;
    bit  hold_off_req   = 1'b0;
    int  bytes_accepted = 0;
    int  stall_cycles   = 0;

    length_prefixed_frame_receiver dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_frame_bytes (m_frame_bytes),
        .m_frame_type  (m_frame_type),
        .m_temp_word   (m_temp_word)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Input beats feed the scoreboard; output beats are checked against it.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.advance_frame(s_data_byte);
            bytes_accepted++;
        end
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_status, m_frame_bytes, m_frame_type, m_temp_word});
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // The long hold-off is taken once, when the stimulus asks for it.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Called and returns at a falling edge.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_config(input logic [7:0] sync_v, input logic [8:0] max_v,
                                input logic [8:0] exp_v, input logic [7:0] type_v);
        logic [1:0] idx [4];
        logic [8:0] val [4];
        idx = '{REG_SYNC_BYTE, REG_MAX_FRAME, REG_EXPECTED_FRAME, REG_EXPECTED_TYPE};
        val = '{{1'b0, sync_v}, max_v, exp_v, {1'b0, type_v}};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            sb.set_register(idx[i], val[i]);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.expected_results.size() != 0)
            @(negedge aclk);
    endtask

    function automatic logic [7:0] body_byte();
        if ($urandom_range(0, 11) == 0)
            return sb.sync_value;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return FR_GOOD;
        if (r < 57) return FR_BAD_LENGTH;
        if (r < 67) return FR_BAD_TYPE;
        if (r < 77) return FR_BAD_XOR;
        if (r < 86) return FR_OVERSIZE;
        if (r < 93) return FR_TRUNCATED;
        return FR_NOISE;
    endfunction

    task automatic send_frame(input frame_kind_t kind_in);
        frame_kind_t kind;
        logic [7:0]  fbytes[$];
        logic [7:0]  chk;
        logic [7:0]  v;
        int          total;
        int          lo;
        int          count;
        kind = kind_in;
        // A buffer of 261 or more bytes cannot overflow.
        if (kind == FR_OVERSIZE && sb.max_frame > 260)
            kind = FR_BAD_LENGTH;
        if (kind == FR_NOISE) begin
            count = $urandom_range(1, 4);
            for (int i = 0; i < count; i++) begin
                v = 8'($urandom_range(0, 255));
                if (v == sb.sync_value && $urandom_range(0, 9) != 0)
                    v = ~v;
                push_byte(v);
            end
            return;
        end
        if (kind == FR_OVERSIZE) begin
            lo = (sb.max_frame > 5) ? sb.max_frame - 5 : 0;
            fbytes.push_back(sb.sync_value);
            for (int i = 1; i < 4; i++)
                fbytes.push_back(body_byte());
            fbytes.push_back(8'($urandom_range(lo, 255)));
        end else begin
            if (sb.expected_frame >= 6 && sb.expected_frame <= 261)
                total = sb.expected_frame;
            else
                total = $urandom_range(6, 40);
            if (kind == FR_BAD_LENGTH) begin
                total = total - 4 + $urandom_range(0, 8);
                if (total < 6 || total > 261)
                    total = 6;
                if (total == sb.expected_frame)
                    total = total + 1;
            end
            fbytes.push_back(sb.sync_value);
            for (int i = 1; i < total; i++)
                fbytes.push_back(body_byte());
            fbytes[3] = sb.expected_type;
            if (kind == FR_BAD_TYPE)
                fbytes[3] = sb.expected_type ^ 8'($urandom_range(1, 255));
            fbytes[4] = 8'(total - 6);
            chk = 8'h00;
            for (int i = 0; i < total - 1; i++)
                chk = chk ^ fbytes[i];
            fbytes[total - 1] = chk;
            if (kind == FR_BAD_XOR)
                fbytes[total - 1] = chk ^ 8'($urandom_range(1, 255));
        end
        count = fbytes.size();
        if (kind == FR_TRUNCATED)
            count = $urandom_range(1, count - 1);
        for (int i = 0; i < count; i++)
            push_byte(fbytes[i]);
    endtask

    // Leaves the block hunting so that registers can change between frames.
    task automatic end_phase();
        while (!sb.is_hunting())
            push_byte(8'h00);
        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        logic [7:0] directed_bytes [25];
        int         start_count;
        int         frames;
        logic [8:0] exp_v;
        sb = new();
        directed_bytes = '{
            8'h00, 8'hFF,                               // ignored while hunting
            8'hBB, 8'hBB, 8'h11, 8'h04, 8'h00, 8'h15,   // accepted, sync inside
            8'hBB, 8'h01, 8'h02, 8'h03, 8'h00, 8'h12,   // wrong type
            8'hBB, 8'h00, 8'hFF, 8'h04, 8'hFF,          // oversize, largest length
            8'hBB, 8'h00, 8'h00, 8'h04, 8'h00, 8'h05    // bad checksum
        };
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_config(8'hBB, 9'd6, 9'd6, 8'h04);
        @(negedge aclk);
        foreach (directed_bytes[i])
            push_byte(directed_bytes[i]);
        end_phase();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            unique case (phase / 4)
                0: begin
                    send_idle_pct = 31;
                    recv_idle_pct = 48;
                end
                1: begin
                    send_idle_pct = 48;
                    recv_idle_pct = 31;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            unique case (phase)
                0: write_config(8'h00, 9'd261, 9'd20, 8'h00);
                1: write_config(8'hFF, 9'd40, 9'd24, 8'hFF);
                2: write_config(8'h5A, 9'd261, 9'd261, 8'h80);
                3: write_config(8'hA5, 9'd30, 9'd19, 8'h7F);
                4: write_config(8'h3C, 9'd4, 9'd6, 8'h01);
                5: write_config(8'hC3, 9'd511, 9'd40, 8'h55);
                8: write_config(8'hBB, 9'd20, 9'd6, 8'h04);
                default: begin
                    exp_v = 9'($urandom_range(6, 32));
                    write_config(8'($urandom_range(0, 255)),
                                 exp_v + 9'($urandom_range(0, 30)),
                                 exp_v, 8'($urandom_range(0, 255)));
                end
            endcase
            @(negedge aclk);
            // Short frames at full rate with the receiver held off back up
            // the output buffer until the input stalls.
            if (phase == 8)
                hold_off_req = 1'b1;
            start_count = bytes_accepted;
            frames = 0;
            while (bytes_accepted - start_count < PHASE_BYTES) begin
                send_frame(pick_kind());
                frames++;
                if (phase == 1 && frames == 3) begin
                    s_valid <= 1'b0;
                    @(negedge aclk);
                    wait_drained();
                end
            end
            end_phase();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.mismatch_count == 0 && sb.expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/lpfr_pkg.sv
hw/rtl/lpfr_parser.sv
hw/rtl/length_prefixed_frame_receiver.sv
tb/tb_top.sv
